@@ sv/sip_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg: shared constants for the segment intersection point block
// Holds the default coordinate width used by the top-level parameter.
// ----------------------------------------------------------------------------
package sip_pkg;

  // Default coordinate width in bits (two's complement, Q11.4 at 16 bits).
  localparam int COORD_WIDTH_DEF = 16;

endpackage
`default_nettype wire

@@ sv/segment_intersection_point.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_point: pipelined 2D segment crossing point
// Takes two segments per item and returns hit flag and crossing point.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one segment pair per item (start and end points
// of segments A and B, signed fixed point). The output channel carries one
// result item per input item: out_hit and the crossing point, which is zero
// when there is no hit. Both channels use valid and stall.
// The datapath is a fixed pipeline: one stage of differences, one of
// products, one of sums and sign tests, one of the Cramer numerator products,
// one that takes magnitudes, then COORD_WIDTH restoring division stages, one
// quotient bit each, and the output register. A new item is accepted every
// cycle while no result is held at the output with out_stall high; the
// division stages set the depth.
// The whole pipeline advances together; when a result waits at the output
// with out_stall high, every stage holds and in_stall is raised, so nothing
// is lost or repeated. Reset clears all valid bits; no payload is reset.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
  parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_seg_b_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic signed [COORD_WIDTH-1:0]      out_cross_x,
  output logic signed [COORD_WIDTH-1:0]      out_cross_y
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;       // coordinate differences
  localparam int PW   = 2 * W + 2;   // products of differences
  localparam int SW   = 2 * W + 3;   // cross products and determinant
  localparam int CW   = 2 * W + 1;   // line constants
  localparam int MW   = 3 * W + 2;   // numerator products
  localparam int NW   = 3 * W + 3;   // numerators

  // Pipeline advance: everything moves unless a result is held at the output.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: coordinate differences.
  // --------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [DW-1:0] ux1_r [4];
  logic signed [DW-1:0] uy1_r [4];
  logic signed [DW-1:0] vx1_r [4];
  logic signed [DW-1:0] vy1_r [4];
  logic signed [DW-1:0] la1_r, ma1_r, lb1_r, mb1_r;
  logic signed [W-1:0]  a0x1_r, a0y1_r, a1x1_r, a1y1_r;
  logic signed [W-1:0]  b0x1_r, b0y1_r, b1x1_r, b1y1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Side of B's endpoints against line A.
      ux1_r[0] <= in_seg_a_start_x - in_seg_b_start_x;
      uy1_r[0] <= in_seg_a_start_y - in_seg_b_start_y;
      vx1_r[0] <= in_seg_a_end_x   - in_seg_b_start_x;
      vy1_r[0] <= in_seg_a_end_y   - in_seg_b_start_y;
      ux1_r[1] <= in_seg_a_start_x - in_seg_b_end_x;
      uy1_r[1] <= in_seg_a_start_y - in_seg_b_end_y;
      vx1_r[1] <= in_seg_a_end_x   - in_seg_b_end_x;
      vy1_r[1] <= in_seg_a_end_y   - in_seg_b_end_y;
      // Side of A's endpoints against line B.
      ux1_r[2] <= in_seg_b_start_x - in_seg_a_start_x;
      uy1_r[2] <= in_seg_b_start_y - in_seg_a_start_y;
      vx1_r[2] <= in_seg_b_end_x   - in_seg_a_start_x;
      vy1_r[2] <= in_seg_b_end_y   - in_seg_a_start_y;
      ux1_r[3] <= in_seg_b_start_x - in_seg_a_end_x;
      uy1_r[3] <= in_seg_b_start_y - in_seg_a_end_y;
      vx1_r[3] <= in_seg_b_end_x   - in_seg_a_end_x;
      vy1_r[3] <= in_seg_b_end_y   - in_seg_a_end_y;
      // Line coefficients.
      la1_r  <= in_seg_a_end_y - in_seg_a_start_y;
      ma1_r  <= in_seg_a_start_x - in_seg_a_end_x;
      lb1_r  <= in_seg_b_end_y - in_seg_b_start_y;
      mb1_r  <= in_seg_b_start_x - in_seg_b_end_x;
      a0x1_r <= in_seg_a_start_x;
      a0y1_r <= in_seg_a_start_y;
      a1x1_r <= in_seg_a_end_x;
      a1y1_r <= in_seg_a_end_y;
      b0x1_r <= in_seg_b_start_x;
      b0y1_r <= in_seg_b_start_y;
      b1x1_r <= in_seg_b_end_x;
      b1y1_r <= in_seg_b_end_y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: all first-level products.
  // --------------------------------------------------------------------------
  logic                     v2_r;
  logic signed [PW-1:0]     p12_r [4];
  logic signed [PW-1:0]     p21_r [4];
  logic signed [PW-1:0]     dpa2_r, dpb2_r;
  logic signed [2*W-1:0]    cap2_r, caq2_r, cbp2_r, cbq2_r;
  logic signed [DW-1:0]     la2_r, ma2_r, lb2_r, mb2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        p12_r[k] <= ux1_r[k] * vy1_r[k];
        p21_r[k] <= uy1_r[k] * vx1_r[k];
      end
      dpa2_r <= la1_r * mb1_r;
      dpb2_r <= ma1_r * lb1_r;
      cap2_r <= a1y1_r * a0x1_r;
      caq2_r <= a1x1_r * a0y1_r;
      cbp2_r <= b1y1_r * b0x1_r;
      cbq2_r <= b1x1_r * b0y1_r;
      la2_r  <= la1_r;
      ma2_r  <= ma1_r;
      lb2_r  <= lb1_r;
      mb2_r  <= mb1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cross products, side test, determinant and line constants.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] crs [4];
  logic                 reject;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      crs[k] = p12_r[k] - p21_r[k];
    end
    // Both endpoints strictly on one side of the other line rejects the pair.
    reject = ((crs[0] > 0) && (crs[1] > 0)) || ((crs[0] < 0) && (crs[1] < 0)) ||
             ((crs[2] > 0) && (crs[3] > 0)) || ((crs[2] < 0) && (crs[3] < 0));
  end

  logic                 v3_r;
  logic                 rej3_r;
  logic signed [SW-1:0] det3_r;
  logic signed [CW-1:0] ca3_r, cb3_r;
  logic signed [DW-1:0] la3_r, ma3_r, lb3_r, mb3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rej3_r <= reject;
      det3_r <= dpa2_r - dpb2_r;
      ca3_r  <= cap2_r - caq2_r;
      cb3_r  <= cbp2_r - cbq2_r;
      la3_r  <= la2_r;
      ma3_r  <= ma2_r;
      lb3_r  <= lb2_r;
      mb3_r  <= mb2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: Cramer numerator products and the no-hit decision.
  // --------------------------------------------------------------------------
  logic                 v4_r;
  logic                 nohit4_r;
  logic signed [SW-1:0] det4_r;
  logic signed [MW-1:0] xp4_r, xq4_r, yp4_r, yq4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nohit4_r <= rej3_r || (det3_r == '0);
      det4_r   <= det3_r;
      xp4_r    <= ca3_r * mb3_r;
      xq4_r    <= ma3_r * cb3_r;
      yp4_r    <= la3_r * cb3_r;
      yq4_r    <= ca3_r * lb3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: numerators, magnitudes and quotient signs.
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        nx_mag, ny_mag;
  logic [SW-1:0]        det_mag;

  always_comb begin
    nx      = xp4_r - xq4_r;
    ny      = yp4_r - yq4_r;
    nx_mag  = nx[NW-1] ? NW'(-nx) : NW'(nx);
    ny_mag  = ny[NW-1] ? NW'(-ny) : NW'(ny);
    det_mag = det4_r[SW-1] ? SW'(-det4_r) : SW'(det4_r);
  end

  // Division stage arrays: index 0 is loaded here, index W is the last stage.
  logic          dv_r    [W+1];
  logic          nohit_r [W+1];
  logic          negx_r  [W+1];
  logic          negy_r  [W+1];
  logic [SW-1:0] den_r   [W+1];
  logic [NW-1:0] remx_r  [W+1];
  logic [NW-1:0] remy_r  [W+1];
  logic [W-1:0]  qx_r    [W+1];
  logic [W-1:0]  qy_r    [W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      nohit_r[0] <= nohit4_r;
      negx_r[0]  <= nx[NW-1] ^ det4_r[SW-1];
      negy_r[0]  <= ny[NW-1] ^ det4_r[SW-1];
      den_r[0]   <= det_mag;
      remx_r[0]  <= nx_mag;
      remy_r[0]  <= ny_mag;
      qx_r[0]    <= '0;
      qy_r[0]    <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring division, one quotient bit per stage, most significant first.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int Bit = W - 1 - j;
    logic [NW-1:0] dsh;
    logic          gex, gey;

    always_comb begin
      dsh = NW'(den_r[j]) << Bit;
      gex = remx_r[j] >= dsh;
      gey = remy_r[j] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nohit_r[j+1] <= nohit_r[j];
        negx_r[j+1]  <= negx_r[j];
        negy_r[j+1]  <= negy_r[j];
        den_r[j+1]   <= den_r[j];
        remx_r[j+1]  <= gex ? remx_r[j] - dsh : remx_r[j];
        remy_r[j+1]  <= gey ? remy_r[j] - dsh : remy_r[j];
        qx_r[j+1]    <= qx_r[j] | (W'(gex) << Bit);
        qy_r[j+1]    <= qy_r[j] | (W'(gey) << Bit);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply signs, zero the point when there is no hit.
  // --------------------------------------------------------------------------
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic signed [W-1:0]  out_x_r, out_y_r;
  logic signed [W-1:0]  out_x_nxt, out_y_nxt;

  always_comb begin
    out_x_nxt = negx_r[W] ? -qx_r[W] : qx_r[W];
    out_y_nxt = negy_r[W] ? -qy_r[W] : qy_r[W];
    if (nohit_r[W]) begin
      out_x_nxt = '0;
      out_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= !nohit_r[W];
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
    end
  end

  // Valid bits travel with the data and are the only reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      for (int k = 0; k <= W; k++) begin
        dv_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      dv_r[0]     <= v4_r;
      for (int k = 0; k < W; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      out_valid_r <= dv_r[W];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

`ifndef SYNTH
  // A result without a hit always carries a zero point.
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("no-hit result with nonzero point");

  // The input is held back exactly when a result waits at the output.
  a_stall_link: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An item in the last division stage reaches the output on a free cycle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[W] && adv) |=> out_valid)
    else $error("item lost between division and output");
`endif

endmodule
`default_nettype wire
